// ----- sv/tkls_pkg.sv -----
// ----------------------------------------------------------------------------
// tkls_pkg
// Shared constants and types of the top-k light selector.
// ----------------------------------------------------------------------------
package tkls_pkg;

   localparam int MAX_SELECTED     = 8;
   localparam int MAX_FRAME_LIGHTS = 256;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CNT_W  = $clog2(MAX_SELECTED + 1);
   localparam int IDX_W  = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;
   localparam int ARR_W  = 9;
   localparam int DIST_W = 34;
   localparam int SCORE_W = 32;
   localparam int NUM_W  = 49;
   localparam int DEN_W  = 35;

   // 1 / 0.0025 scaled to Q.8 of the squared distance
   localparam logic [16:0] SCORE_SCALE = 17'd102400;

   // configuration register indexes
   localparam logic [7:0] CSR_CAMERA_X = 8'd0;
   localparam logic [7:0] CSR_CAMERA_Y = 8'd1;
   localparam logic [7:0] CSR_CAMERA_Z = 8'd2;
   localparam logic [7:0] CSR_LIMIT    = 8'd3;

   typedef struct packed {
      logic [7:0]         index;
      logic [DIST_W-1:0]  sq_range;
      logic [SCORE_W-1:0] score;
      logic               dark;
      logic               last;
      logic [ARR_W-1:0]   requested;
   } light_type;

   typedef struct packed {
      logic signed [15:0] cam_x;
      logic signed [15:0] cam_y;
      logic signed [15:0] cam_z;
      logic [7:0]         limit;
   } cfg_type;

endpackage

// ----- sv/tkls_front.sv -----
// ----------------------------------------------------------------------------
// tkls_front
// Accepts lights, forms the squared distance and divides out the score.
// ----------------------------------------------------------------------------
module tkls_front (
   input  logic                clock,
   input  logic                reset,
   input  tkls_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [15:0]  pos_x,
   input  logic signed [15:0]  pos_y,
   input  logic signed [15:0]  pos_z,
   input  logic [15:0]         radius,
   input  logic                is_dark,
   input  logic                last_light,
   output logic                push,
   input  logic                queue_full,
   output tkls_pkg::light_type push_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [tkls_pkg::ARR_W-1:0] arrivals_ff, arrivals_in;
   logic [5:0] step_ff, step_in;

   logic [15:0] ax_ff, ay_ff, az_ff, r_ff;
   logic [31:0] sx_ff, sy_ff, sz_ff, rsq_ff;
   logic [tkls_pkg::DIST_W-1:0] dist_ff;
   logic [tkls_pkg::NUM_W-1:0] num_ff;
   logic [tkls_pkg::DEN_W-1:0] den_ff;
   logic [tkls_pkg::DEN_W:0] rem_ff;
   logic [7:0] index_ff;
   logic dark_ff, last_ff;
   logic [tkls_pkg::ARR_W-1:0] req_ff;

   logic signed [16:0] dx, dy, dz;
   logic [15:0] adx, ady, adz;
   logic [tkls_pkg::ARR_W-1:0] arr_next;
   logic frame_end;
   logic [tkls_pkg::DEN_W:0] rem_sh, rem_sub;
   logic qbit;

   always_comb begin
      dx  = 17'(pos_x) - 17'(cfg.cam_x);
      dy  = 17'(pos_y) - 17'(cfg.cam_y);
      dz  = 17'(pos_z) - 17'(cfg.cam_z);
      adx = dx[16] ? 16'(-dx) : dx[15:0];
      ady = dy[16] ? 16'(-dy) : dy[15:0];
      adz = dz[16] ? 16'(-dz) : dz[15:0];
      arr_next  = arrivals_ff + 1'b1;
      frame_end = last_light || (arr_next >= tkls_pkg::ARR_W'(tkls_pkg::MAX_FRAME_LIGHTS));
      rem_sh  = {rem_ff[tkls_pkg::DEN_W-1:0], num_ff[tkls_pkg::NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = !rem_sub[tkls_pkg::DEN_W];
   end

   always_comb begin
      state_in    = state_ff;
      arrivals_in = arrivals_ff;
      step_in     = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in    = ST_SQ;
               arrivals_in = frame_end ? '0 : arr_next;
            end
         end
         ST_SQ:  state_in = ST_SUM;
         ST_SUM: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(tkls_pkg::NUM_W - 1)) state_in = ST_PUSH;
         end
         ST_PUSH: if (!queue_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         arrivals_ff <= '0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         arrivals_ff <= arrivals_in;
         step_ff     <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && in_valid) begin
         ax_ff    <= adx;
         ay_ff    <= ady;
         az_ff    <= adz;
         r_ff     <= radius;
         index_ff <= arrivals_ff[7:0];
         dark_ff  <= is_dark;
         last_ff  <= frame_end;
         req_ff   <= arr_next;
      end
      if (state_ff == ST_SQ) begin
         sx_ff  <= ax_ff * ax_ff;
         sy_ff  <= ay_ff * ay_ff;
         sz_ff  <= az_ff * az_ff;
         rsq_ff <= r_ff * r_ff;
      end
      if (state_ff == ST_SUM) begin
         dist_ff <= tkls_pkg::DIST_W'(sx_ff) + tkls_pkg::DIST_W'(sy_ff)
                  + tkls_pkg::DIST_W'(sz_ff);
         num_ff  <= tkls_pkg::NUM_W'(rsq_ff) * tkls_pkg::NUM_W'(tkls_pkg::SCORE_SCALE);
         den_ff  <= tkls_pkg::DEN_W'(tkls_pkg::SCORE_SCALE) + tkls_pkg::DEN_W'(sx_ff)
                  + tkls_pkg::DEN_W'(sy_ff) + tkls_pkg::DEN_W'(sz_ff);
         rem_ff  <= '0;
      end
      if (state_ff == ST_DIV) begin
         // Restoring division: numerator bits shift out, quotient bits shift in.
         rem_ff <= qbit ? rem_sub : rem_sh;
         num_ff <= {num_ff[tkls_pkg::NUM_W-2:0], qbit};
      end
   end

   assign in_ready = (state_ff == ST_IDLE);
   assign push     = (state_ff == ST_PUSH) && !queue_full;

   always_comb begin
      push_data.index     = index_ff;
      push_data.sq_range  = dist_ff;
      push_data.score     = num_ff[tkls_pkg::SCORE_W-1:0];
      push_data.dark      = dark_ff;
      push_data.last      = last_ff;
      push_data.requested = req_ff;
   end

endmodule

// ----- sv/tkls_queue.sv -----
// ----------------------------------------------------------------------------
// tkls_queue
// Short queue of classified lights between front and back.
// ----------------------------------------------------------------------------
module tkls_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tkls_pkg::light_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output tkls_pkg::light_type head
);

   localparam int PTR_W = (tkls_pkg::QUEUE_DEPTH > 1) ? $clog2(tkls_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(tkls_pkg::QUEUE_DEPTH + 1);

   tkls_pkg::light_type slot_ff [tkls_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [CNT_QW-1:0] count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(tkls_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= bump(wr_ff);
         if (pop)  rd_ff <= bump(rd_ff);
         count_ff <= count_ff + CNT_QW'(push) - CNT_QW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assign full      = (count_ff == CNT_QW'(tkls_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

endmodule

// ----- sv/tkls_back.sv -----
// ----------------------------------------------------------------------------
// tkls_back
// Sorted insertion into the kept list and emission at frame end.
// ----------------------------------------------------------------------------
module tkls_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          limit,
   input  logic                queue_valid,
   output logic                pop,
   input  tkls_pkg::light_type head,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_entry_valid,
   output logic [7:0]          rsp_index,
   output logic [tkls_pkg::DIST_W-1:0]  rsp_dist,
   output logic [tkls_pkg::SCORE_W-1:0] rsp_score,
   output logic                rsp_dark,
   output logic [6:0]          rsp_selected,
   output logic [8:0]          rsp_requested,
   output logic [6:0]          rsp_shade_total,
   output logic                rsp_last
);

   localparam int CW = tkls_pkg::CNT_W;
   localparam int MS = tkls_pkg::MAX_SELECTED;
   localparam int IDX_SEL = tkls_pkg::IDX_W;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                         state_ff;
   logic [CW-1:0]                total_ff, total_in, emit_ff;
   logic [tkls_pkg::ARR_W-1:0]   req_ff;
   logic [7:0]                   k_index_ff [MS];
   logic [tkls_pkg::DIST_W-1:0]  k_dist_ff  [MS];
   logic [tkls_pkg::SCORE_W-1:0] k_score_ff [MS];
   logic                         k_dark_ff  [MS];
   logic                         out_valid_ff;

   logic [CW-1:0] lim, pos;
   logic          found, insert, advance, final_one;
   logic [6:0]    dark_sum;
   logic [IDX_SEL-1:0] sel;

   always_comb begin
      lim   = (limit > 8'(MS)) ? CW'(MS) : CW'(limit);
      pos   = total_ff;
      found = 1'b0;
      for (int j = 0; j < MS; j++) begin
         if (!found && CW'(j) < total_ff && head.score > k_score_ff[j]) begin
            pos   = CW'(j);
            found = 1'b1;
         end
      end
      insert   = !(pos >= lim && total_ff >= lim);
      total_in = (total_ff < lim) ? total_ff + 1'b1 : total_ff;
      dark_sum = '0;
      for (int j = 0; j < MS; j++)
         dark_sum = dark_sum + 7'(CW'(j) < total_ff && k_dark_ff[j]);
      sel       = emit_ff[IDX_SEL-1:0];
      advance   = !out_valid_ff || rsp_ready;
      final_one = (total_ff == '0) || (emit_ff + 1'b1 == total_ff);
   end

   assign pop = (state_ff == ST_IDLE) && queue_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // The output register refills only while emitting.
         if (advance) out_valid_ff <= (state_ff == ST_EMIT);
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (insert) total_ff <= total_in;
                  emit_ff <= '0;
                  if (head.last) state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (advance) begin
                  emit_ff <= emit_ff + 1'b1;
                  if (final_one) begin
                     total_ff <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // kept list and result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         req_ff <= head.requested;
         if (insert) begin
            for (int j = 0; j < MS; j++) begin
               if (CW'(j) == pos) begin
                  k_index_ff[j] <= head.index;
                  k_dist_ff[j]  <= head.sq_range;
                  k_score_ff[j] <= head.score;
                  k_dark_ff[j]  <= head.dark;
               end else if (j > 0 && CW'(j) > pos) begin
                  k_index_ff[j] <= k_index_ff[j-1];
                  k_dist_ff[j]  <= k_dist_ff[j-1];
                  k_score_ff[j] <= k_score_ff[j-1];
                  k_dark_ff[j]  <= k_dark_ff[j-1];
               end
            end
         end
      end
      if (state_ff == ST_EMIT && advance) begin
         rsp_entry_valid <= (total_ff != '0);
         rsp_index       <= (total_ff != '0) ? k_index_ff[sel] : '0;
         rsp_dist        <= (total_ff != '0) ? k_dist_ff[sel]  : '0;
         rsp_score       <= (total_ff != '0) ? k_score_ff[sel] : '0;
         rsp_dark        <= (total_ff != '0) && k_dark_ff[sel];
         rsp_selected    <= 7'(total_ff);
         rsp_requested   <= req_ff;
         rsp_shade_total <= dark_sum;
         rsp_last        <= final_one;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MS)) else $error("kept list overfilled");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && total_ff != '0 |-> emit_ff < total_ff)
      else $error("emission index beyond kept list");
   a_marker: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_entry_valid |-> rsp_selected == '0 && rsp_last)
      else $error("empty marker malformed");
   a_no_pop_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !pop) else $error("light taken during emission");

endmodule

// ----- sv/top_k_light_selector_unit.sv -----
// ----------------------------------------------------------------------------
// top_k_light_selector_unit
// Keeps the highest-scoring point lights of a frame and emits them in order.
// ----------------------------------------------------------------------------
// The front end takes a light, squares, sums, then runs a restoring divider
// that produces one of 49 quotient bits per cycle, and hands the classified
// light to a two-entry queue, waiting while it is full; it takes no new light
// before then. The back end takes a light from the queue whenever it is idle,
// placing it in a sorted list of up to eight entries, so the divider sets the
// rate. After the last light of a frame (tlast, or the 256th light) the back
// end emits one result item per kept light, best score first, or a single
// empty marker when nothing was kept; the next frame's lights are computed
// meanwhile but wait in the queue until emission ends.
// Configuration writes are always accepted. The camera is sampled when a light
// is taken and the budget when the back end picks the light up, so registers
// should be written only while no light is in flight.
// ----------------------------------------------------------------------------
module top_k_light_selector_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [15:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // pos_x, pos_y, pos_z, light_radius
   input  logic [0:0]   req_tuser,   // is_dark
   input  logic         req_tlast,   // last_light
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // light_index, squared range, score, selected_count, offered total,
   // dark total, zero padding
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // entry_valid, dark_flag
   output logic         rsp_tlast    // last_result
);

   tkls_pkg::cfg_type   cfg_ff;
   tkls_pkg::light_type push_data, head;
   logic push, queue_full, queue_valid, pop;
   logic entry_valid, dark;
   logic [7:0]  index;
   logic [tkls_pkg::DIST_W-1:0]  sq_range;
   logic [tkls_pkg::SCORE_W-1:0] score;
   logic [6:0] selected, shade_total;
   logic [8:0] requested;

   assign csr_ready = 1'b1;

   // The register file accepts a write in every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x <= '0;
         cfg_ff.cam_y <= '0;
         cfg_ff.cam_z <= '0;
         cfg_ff.limit <= 8'(tkls_pkg::MAX_SELECTED);
      end else if (csr_valid) begin
         unique case (csr_index)
            tkls_pkg::CSR_CAMERA_X: cfg_ff.cam_x <= csr_data;
            tkls_pkg::CSR_CAMERA_Y: cfg_ff.cam_y <= csr_data;
            tkls_pkg::CSR_CAMERA_Z: cfg_ff.cam_z <= csr_data;
            tkls_pkg::CSR_LIMIT:    cfg_ff.limit <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   tkls_front u_front (
      .clock, .reset,
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .pos_x      (req_tdata[15:0]),
      .pos_y      (req_tdata[31:16]),
      .pos_z      (req_tdata[47:32]),
      .radius     (req_tdata[63:48]),
      .is_dark    (req_tuser[0]),
      .last_light (req_tlast),
      .push, .queue_full, .push_data
   );

   tkls_queue u_queue (
      .clock, .reset, .push, .push_data,
      .full      (queue_full),
      .pop,
      .not_empty (queue_valid),
      .head
   );

   tkls_back u_back (
      .clock, .reset,
      .limit           (cfg_ff.limit),
      .queue_valid, .pop, .head,
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_entry_valid (entry_valid),
      .rsp_index       (index),
      .rsp_dist        (sq_range),
      .rsp_score       (score),
      .rsp_dark        (dark),
      .rsp_selected    (selected),
      .rsp_requested   (requested),
      .rsp_shade_total (shade_total),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, shade_total, requested, selected, score, sq_range, index};
   assign rsp_tuser = {dark, entry_valid};

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the top-k light selector.
// ----------------------------------------------------------------------------
// Light items are driven on the request stream, often with random gaps. Each accepted
// item goes into a scoreboard that predicts the kept list on its own. Every
// result item is checked field by field against the oldest predicted result.
// The camera and budget registers are changed only once the block has gone
// quiet.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic        valid;
      logic [7:0]  index;
      logic [33:0] sq_range;
      logic [31:0] score;
      logic        dark;
      logic [6:0]  sel_count;
      logic [8:0]  req_count;
      logic [6:0]  shade_total;
      logic        last;
   } selection_type;

   // Keeps its own copy of the camera, the budget and the kept list, and
   // queues the results that each frame should produce.
   class light_scoreboard;
      logic signed [15:0] cam_x, cam_y, cam_z;
      logic [7:0]         limit;
      logic [7:0]         kept_idx[tkls_pkg::MAX_SELECTED];
      logic [33:0]        kept_dist[tkls_pkg::MAX_SELECTED];
      logic [31:0]        kept_score[tkls_pkg::MAX_SELECTED];
      logic               kept_dark[tkls_pkg::MAX_SELECTED];
      int                 kept_n;
      int                 arrived;
      selection_type      pending[$];
      int                 errors;

      function new();
         cam_x = 0; cam_y = 0; cam_z = 0; limit = 8;
         kept_n = 0; arrived = 0; errors = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [15:0] val);
         case (idx)
            tkls_pkg::CSR_CAMERA_X: cam_x = val;
            tkls_pkg::CSR_CAMERA_Y: cam_y = val;
            tkls_pkg::CSR_CAMERA_Z: cam_z = val;
            tkls_pkg::CSR_LIMIT:    limit = val[7:0];
            default: ;
         endcase
      endfunction

      function logic [33:0] square_gap(logic signed [15:0] a, logic signed [15:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return 34'(d * d);
      endfunction

      function void note_light(logic signed [15:0] px, logic signed [15:0] py,
                               logic signed [15:0] pz, logic [15:0] rad,
                               logic dark, logic tl);
         logic [33:0]  dsq;
         logic [63:0]  rsq;
         logic [31:0]  sc;
         int           lim, pos, j, dcnt, mine;
         logic         fin;
         selection_type s;
         mine = arrived;
         arrived++;
         fin = tl || arrived >= tkls_pkg::MAX_FRAME_LIGHTS;
         dsq = square_gap(px, cam_x) + square_gap(py, cam_y) + square_gap(pz, cam_z);
         rsq = 64'(rad) * 64'(rad);
         sc = 32'((rsq * 64'd102400) / (64'd102400 + 64'(dsq)));
         lim = (limit > tkls_pkg::MAX_SELECTED) ? tkls_pkg::MAX_SELECTED : int'(limit);
         pos = kept_n;
         for (j = 0; j < kept_n; j++)
            if (sc > kept_score[j]) begin
               pos = j;
               break;
            end
         if (!(pos >= lim && kept_n >= lim)) begin
            if (kept_n < lim) kept_n++;
            for (j = kept_n - 1; j > pos; j--) begin
               kept_idx[j] = kept_idx[j-1]; kept_dist[j] = kept_dist[j-1];
               kept_score[j] = kept_score[j-1]; kept_dark[j] = kept_dark[j-1];
            end
            kept_idx[pos] = 8'(mine); kept_dist[pos] = dsq;
            kept_score[pos] = sc; kept_dark[pos] = dark;
         end
         if (!fin) return;
         dcnt = 0;
         for (j = 0; j < kept_n; j++) dcnt += kept_dark[j];
         if (kept_n == 0) begin
            s = '{1'b0, 8'd0, 34'd0, 32'd0, 1'b0, 7'd0, 9'(arrived), 7'd0, 1'b1};
            pending.push_back(s);
         end
         for (j = 0; j < kept_n; j++) begin
            s = '{1'b1, kept_idx[j], kept_dist[j], kept_score[j], kept_dark[j],
                  7'(kept_n), 9'(arrived), 7'(dcnt), (j == kept_n - 1)};
            pending.push_back(s);
         end
         kept_n = 0;
         arrived = 0;
      endfunction

      function void check_result(selection_type got);
         selection_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item, light_index %0d", got.index);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.valid !== e.valid) begin
            $error("entry_valid: expected %0d, got %0d", e.valid, got.valid); errors++;
         end
         if (got.index !== e.index) begin
            $error("light_index: expected %0d, got %0d", e.index, got.index); errors++;
         end
         if (got.sq_range !== e.sq_range) begin
            $error("squared_range: expected %0d, got %0d", e.sq_range, got.sq_range);
            errors++;
         end
         if (got.score !== e.score) begin
            $error("score: expected %0d, got %0d", e.score, got.score); errors++;
         end
         if (got.dark !== e.dark) begin
            $error("dark_flag: expected %0d, got %0d", e.dark, got.dark); errors++;
         end
         if (got.sel_count !== e.sel_count) begin
            $error("selected_count: expected %0d, got %0d", e.sel_count, got.sel_count);
            errors++;
         end
         if (got.req_count !== e.req_count) begin
            $error("offered_total: expected %0d, got %0d", e.req_count, got.req_count);
            errors++;
         end
         if (got.shade_total !== e.shade_total) begin
            $error("shade_total: expected %0d, got %0d", e.shade_total, got.shade_total);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last_result: expected %0d, got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_index;
   logic [15:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   light_scoreboard board;
   int  hold_cycles;    // long receiver hold-off, counted down by the sink

   top_k_light_selector_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest correct run is far below this.
   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Picks a gap length: mostly none or short, now and then long.
   function int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // Result sink: stalls at random and checks each accepted result item.
   initial begin
      selection_type got;
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
            @(posedge clock);
         end else begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) begin
               got.index       = rsp_tdata[7:0];
               got.sq_range    = rsp_tdata[41:8];
               got.score       = rsp_tdata[73:42];
               got.sel_count   = rsp_tdata[80:74];
               got.req_count   = rsp_tdata[89:81];
               got.shade_total = rsp_tdata[96:90];
               got.valid       = rsp_tuser[0];
               got.dark        = rsp_tuser[1];
               got.last        = rsp_tlast;
               board.check_result(got);
            end
         end
      end
   end

   // Offers one light item and waits until it is taken.
   task automatic send_light(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz, logic [15:0] rad,
                             logic dark, logic tl, bit gaps);
      int g;
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rad, pz, py, px};
      req_tuser  <= dark;
      req_tlast  <= tl;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_light(px, py, pz, rad, dark, tl);
   endtask

   task automatic idle_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every predicted result, then lets the block settle.
   task automatic drain();
      idle_request();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic set_camera(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      write_reg(tkls_pkg::CSR_CAMERA_X, x);
      write_reg(tkls_pkg::CSR_CAMERA_Y, y);
      write_reg(tkls_pkg::CSR_CAMERA_Z, z);
   endtask

   // One random frame. Radii are drawn from a few small sets now and then,
   // so that equal scores turn up.
   task automatic random_frame(int n, bit gaps);
      int i;
      logic [15:0] rad;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: rad = 16'($urandom_range(0, 3) * 16);
            1: rad = 16'($urandom);
            2: rad = 16'($urandom_range(0, 255));
            default: rad = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
         endcase
         if ($urandom_range(0, 3) == 0)
            send_light(16'sd0, 16'sd0, 16'sd0, rad, 1'($urandom), i == n - 1, gaps);
         else
            send_light(16'($urandom), 16'($urandom), 16'($urandom), rad,
                       1'($urandom), i == n - 1, gaps);
      end
   endtask

   initial begin
      int i, n;
      board       = new();
      hold_cycles = 0;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Field extremes with the camera at reset values.
      send_light(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_light(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
      send_light(16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_light(16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0, 1'b0);
      // Equal scores: the later light stays behind.
      send_light(16'sd16, 16'sd0, 16'sd0, 16'd100, 1'b0, 1'b0, 1'b0);
      send_light(16'sd16, 16'sd0, 16'sd0, 16'd100, 1'b1, 1'b1, 1'b0);
      drain();

      // Camera at the opposite corner: largest possible distance.
      set_camera(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_light(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1, 1'b1, 1'b0);
      drain();

      // Zero budget gives the empty marker.
      write_reg(tkls_pkg::CSR_LIMIT, 16'd0);
      send_light(16'sd5, 16'sd5, 16'sd5, 16'd50, 1'b1, 1'b0, 1'b0);
      send_light(16'sd5, 16'sd5, 16'sd5, 16'd60, 1'b0, 1'b1, 1'b0);
      drain();

      // A budget above the list depth is clamped; more lights than fit.
      write_reg(tkls_pkg::CSR_LIMIT, 16'd255);
      set_camera(16'h8000, 16'h0000, 16'h1234);
      random_frame(12, 1'b0);
      drain();

      // Budget lowered between frames, after a full frame at the old budget.
      // The block is let go quiet before the write.
      write_reg(tkls_pkg::CSR_LIMIT, 16'd8);
      random_frame(5, 1'b0);
      drain();
      write_reg(tkls_pkg::CSR_LIMIT, 16'd2);
      send_light(16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, 1'b1, 1'b0);
      drain();

      // Frame overflow: 256 lights without tlast end the frame themselves.
      write_reg(tkls_pkg::CSR_LIMIT, 16'd3);
      for (i = 0; i < tkls_pkg::MAX_FRAME_LIGHTS; i++)
         send_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    1'($urandom), 1'b0, 1'b0);
      drain();

      // Long receiver hold-off while frames keep coming, so the queue fills.
      write_reg(tkls_pkg::CSR_LIMIT, 16'd8);
      hold_cycles = 600;
      for (i = 0; i < 6; i++) random_frame(2, 1'b0);
      drain();

      // Random part: short frames with a fresh setting every few frames.
      n = 0;
      while (n < 160) begin
         if ($urandom_range(0, 2) == 0) begin
            drain();
            set_camera(16'($urandom), 16'($urandom), 16'($urandom));
            write_reg(tkls_pkg::CSR_LIMIT, ($urandom_range(0, 4) == 0)
                      ? 16'($urandom_range(0, 255)) : 16'($urandom_range(0, 9)));
         end
         i = $urandom_range(1, 12);
         random_frame(i, $urandom_range(0, 3) != 0);
         n += i;
         // Sometimes wait until every result has come before going on.
         if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
      repeat (100) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
